// File: hw/rtl/i2c_mbe_pkg.sv
// i2c_mbe_pkg: shared types, constants and helpers for the I2C master byte engine.
// No dependencies; used by the channel interfaces and the top level.
package i2c_mbe_pkg;

  localparam int OP_W          = 3;
  localparam int BYTE_W        = 8;
  localparam int UNIT_W        = 16;
  localparam int ACK_W         = 10;
  localparam int DLY_W         = 19;
  localparam int BIT_CNT_W     = 4;
  localparam int BITS_PER_BYTE = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_UNIT_TICKS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT = 1'b1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET  = 16'd100;
  localparam logic [ACK_W-1:0]  ACK_TIMEOUT_RESET = 10'd500;

  typedef enum logic [18:0] {
    PH_IDLE   = 19'h00001,
    PH_S_A    = 19'h00002,
    PH_S_B    = 19'h00004,
    PH_S_C    = 19'h00008,
    PH_T_A    = 19'h00010,
    PH_T_B    = 19'h00020,
    PH_T_C    = 19'h00040,
    PH_W_PRE  = 19'h00080,
    PH_W_LOW  = 19'h00100,
    PH_W_HIGH = 19'h00200,
    PH_W_TAIL = 19'h00400,
    PH_A_REL  = 19'h00800,
    PH_A_HIGH = 19'h01000,
    PH_A_POLL = 19'h02000,
    PH_R_LOW  = 19'h04000,
    PH_R_HIGH = 19'h08000,
    PH_K_LOW  = 19'h10000,
    PH_K_DATA = 19'h20000,
    PH_K_HIGH = 19'h40000
  } phase_t;

  // Ticks for a wait of two or five delay units; a zero unit counts as one.
  function automatic logic [DLY_W-1:0] wait_ticks(input logic [UNIT_W-1:0] unit,
                                                  input logic five);
    logic [DLY_W-1:0] u;
    u = (unit == '0) ? DLY_W'(1) : DLY_W'(unit);
    return five ? ((u << 2) + u) : (u << 1);
  endfunction

endpackage

// File: hw/rtl/i2c_mbe_if.sv
// Channel interfaces of the I2C master byte engine: command beats in, result beats out.
// Depends on i2c_mbe_pkg for field widths.
interface i2c_mbe_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [i2c_mbe_pkg::OP_W-1:0]      operation;
  logic [i2c_mbe_pkg::BYTE_W-1:0]    write_data;
  logic                              send_ack;
  logic                              sda_in;

  modport source (output valid, output operation, output write_data, output send_ack,
                  output sda_in, input ready);
  modport sink   (input valid, input operation, input write_data, input send_ack,
                  input sda_in, output ready);
endinterface

interface i2c_mbe_res_if;
  logic                              valid;
  logic                              ready;
  logic                              scl_out;
  logic                              sda_out;
  logic                              busy_res;
  logic                              done_res;
  logic [i2c_mbe_pkg::BYTE_W-1:0]    read_data;
  logic                              no_ack;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output read_data, output no_ack, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input read_data, input no_ack, output ready);
endinterface

// File: hw/rtl/i2c_master_byte_engine_unit.sv
// I2C master byte engine: one result beat per command/tick beat, one beat per cycle while results are taken.
// The bus state is updated and the result registered on the accepting edge.
// Throughput 1 beat per cycle; cmd.ready drops only while a registered result is not taken.
// Reset (rst, synchronous): idle, SCL and SDA released, no_ack and read byte cleared,
// unit_ticks = 100, ack_timeout = 500. Depends on i2c_mbe_pkg and i2c_mbe_if.
module i2c_master_byte_engine_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [i2c_mbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [i2c_mbe_pkg::CFG_DATA_W-1:0]    cfg_data,
  i2c_mbe_cmd_if.sink                           cmd,
  i2c_mbe_res_if.source                         res
);

  logic [i2c_mbe_pkg::UNIT_W-1:0]    unit_ticks;
  logic [i2c_mbe_pkg::ACK_W-1:0]     ack_timeout;

  i2c_mbe_pkg::phase_t               phase, phase_next, enter_ph;
  logic [i2c_mbe_pkg::DLY_W-1:0]     delay_count, delay_count_next, dly_dec;
  logic [i2c_mbe_pkg::BIT_CNT_W-1:0] bit_count, bit_count_next, bit_inc;
  logic [i2c_mbe_pkg::BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic [i2c_mbe_pkg::ACK_W-1:0]     ack_wait_count, ack_wait_count_next;
  logic                              scl_level, scl_level_next;
  logic                              sda_level, sda_level_next;
  logic                              ack_choice, ack_choice_next;
  logic                              nack_flag, nack_flag_next;
  logic [i2c_mbe_pkg::BYTE_W-1:0]    read_reg, read_reg_next;
  logic                              enter_en;
  logic                              done;
  logic                              accept;

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign bit_inc   = bit_count + 1'b1;
  assign dly_dec   = (delay_count != '0) ? delay_count - 1'b1 : '0;

  always_comb begin
    phase_next          = phase;
    delay_count_next    = delay_count;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    ack_wait_count_next = ack_wait_count;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    ack_choice_next     = ack_choice;
    nack_flag_next      = nack_flag;
    read_reg_next       = read_reg;
    enter_en            = 1'b0;
    enter_ph            = i2c_mbe_pkg::PH_IDLE;
    done                = 1'b0;

    if (cmd.operation == i2c_mbe_pkg::OP_TICK) begin
      if (phase == i2c_mbe_pkg::PH_A_POLL) begin
        if (!cmd.sda_in) begin
          scl_level_next = 1'b0;
          nack_flag_next = 1'b0;
          enter_en       = 1'b1;
          enter_ph       = i2c_mbe_pkg::PH_IDLE;
          done           = 1'b1;
        end else if (ack_wait_count >= ack_timeout) begin
          nack_flag_next = 1'b1;
          enter_en       = 1'b1;
          enter_ph       = i2c_mbe_pkg::PH_T_A;
        end else begin
          ack_wait_count_next = ack_wait_count + 1'b1;
        end
      end else if (phase != i2c_mbe_pkg::PH_IDLE) begin
        delay_count_next = dly_dec;
        if (dly_dec == '0) begin
          // current wait is over: move to the next phase of the sequence, or to idle at its end
          enter_en = 1'b1;
          unique case (phase)
            i2c_mbe_pkg::PH_S_A:    enter_ph = i2c_mbe_pkg::PH_S_B;
            i2c_mbe_pkg::PH_S_B:    enter_ph = i2c_mbe_pkg::PH_S_C;
            i2c_mbe_pkg::PH_S_C: begin
              scl_level_next = 1'b0;
              done           = 1'b1;
            end
            i2c_mbe_pkg::PH_T_A:    enter_ph = i2c_mbe_pkg::PH_T_B;
            i2c_mbe_pkg::PH_T_B:    enter_ph = i2c_mbe_pkg::PH_T_C;
            i2c_mbe_pkg::PH_T_C: begin
              sda_level_next = 1'b1;
              done           = 1'b1;
            end
            i2c_mbe_pkg::PH_W_PRE: begin
              scl_level_next = 1'b0;
              bit_count_next = '0;
              enter_ph       = i2c_mbe_pkg::PH_W_LOW;
            end
            i2c_mbe_pkg::PH_W_LOW:  enter_ph = i2c_mbe_pkg::PH_W_HIGH;
            i2c_mbe_pkg::PH_W_HIGH: enter_ph = i2c_mbe_pkg::PH_W_TAIL;
            i2c_mbe_pkg::PH_W_TAIL: begin
              bit_count_next = bit_inc;
              enter_ph = (bit_inc < i2c_mbe_pkg::BIT_CNT_W'(i2c_mbe_pkg::BITS_PER_BYTE)) ?
                         i2c_mbe_pkg::PH_W_LOW : i2c_mbe_pkg::PH_A_REL;
            end
            i2c_mbe_pkg::PH_A_REL:  enter_ph = i2c_mbe_pkg::PH_A_HIGH;
            i2c_mbe_pkg::PH_A_HIGH: enter_ph = i2c_mbe_pkg::PH_A_POLL;
            i2c_mbe_pkg::PH_R_LOW: begin
              shift_byte_next = {shift_byte[i2c_mbe_pkg::BYTE_W-2:0], cmd.sda_in};
              enter_ph        = i2c_mbe_pkg::PH_R_HIGH;
            end
            i2c_mbe_pkg::PH_R_HIGH: begin
              bit_count_next = bit_inc;
              enter_ph = (bit_inc < i2c_mbe_pkg::BIT_CNT_W'(i2c_mbe_pkg::BITS_PER_BYTE)) ?
                         i2c_mbe_pkg::PH_R_LOW : i2c_mbe_pkg::PH_K_LOW;
            end
            i2c_mbe_pkg::PH_K_LOW:  enter_ph = i2c_mbe_pkg::PH_K_DATA;
            i2c_mbe_pkg::PH_K_DATA: enter_ph = i2c_mbe_pkg::PH_K_HIGH;
            i2c_mbe_pkg::PH_K_HIGH: begin
              scl_level_next = 1'b0;
              read_reg_next  = shift_byte;
              done           = 1'b1;
            end
            default:                enter_ph = i2c_mbe_pkg::PH_IDLE;
          endcase
        end
      end
    end else if (cmd.operation <= i2c_mbe_pkg::OP_READ && phase == i2c_mbe_pkg::PH_IDLE) begin
      enter_en = 1'b1;
      unique case (cmd.operation)
        i2c_mbe_pkg::OP_START: enter_ph = i2c_mbe_pkg::PH_S_A;
        i2c_mbe_pkg::OP_STOP:  enter_ph = i2c_mbe_pkg::PH_T_A;
        i2c_mbe_pkg::OP_WRITE: begin
          shift_byte_next = cmd.write_data;
          nack_flag_next  = 1'b0;
          enter_ph        = i2c_mbe_pkg::PH_W_PRE;
        end
        default: begin
          shift_byte_next = '0;
          bit_count_next  = '0;
          ack_choice_next = cmd.send_ack;
          enter_ph        = i2c_mbe_pkg::PH_R_LOW;
        end
      endcase
    end

    // phase entry: set the bus levels and load the wait
    if (enter_en) begin
      phase_next       = enter_ph;
      delay_count_next = '0;
      unique case (enter_ph)
        i2c_mbe_pkg::PH_S_A: begin
          sda_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_S_B: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b1);
        end
        i2c_mbe_pkg::PH_S_C: begin
          sda_level_next   = 1'b0;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b1);
        end
        i2c_mbe_pkg::PH_T_A: begin
          scl_level_next   = 1'b0;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_T_B: begin
          sda_level_next   = 1'b0;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b1);
        end
        i2c_mbe_pkg::PH_T_C: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b1);
        end
        i2c_mbe_pkg::PH_W_PRE: begin
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_W_LOW: begin
          sda_level_next   = shift_byte_next[i2c_mbe_pkg::BYTE_W-1];
          shift_byte_next  = {shift_byte_next[i2c_mbe_pkg::BYTE_W-2:0], 1'b0};
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_W_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_W_TAIL: begin
          scl_level_next   = 1'b0;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_A_REL: begin
          sda_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_A_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_A_POLL: ack_wait_count_next = '0;
        i2c_mbe_pkg::PH_R_LOW: begin
          scl_level_next   = 1'b0;
          sda_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_R_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_K_LOW: begin
          scl_level_next   = 1'b0;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_K_DATA: begin
          sda_level_next   = !ack_choice_next;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        i2c_mbe_pkg::PH_K_HIGH: begin
          scl_level_next   = 1'b1;
          delay_count_next = i2c_mbe_pkg::wait_ticks(unit_ticks, 1'b0);
        end
        default: phase_next = i2c_mbe_pkg::PH_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks  <= i2c_mbe_pkg::UNIT_TICKS_RESET;
      ack_timeout <= i2c_mbe_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2c_mbe_pkg::REG_UNIT_TICKS:  unit_ticks  <= cfg_data[i2c_mbe_pkg::UNIT_W-1:0];
        i2c_mbe_pkg::REG_ACK_TIMEOUT: ack_timeout <= cfg_data[i2c_mbe_pkg::ACK_W-1:0];
        default: ;
      endcase
    end
  end

  // bus state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= i2c_mbe_pkg::PH_IDLE;
      scl_level <= 1'b1;
      sda_level <= 1'b1;
      nack_flag <= 1'b0;
      read_reg  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      scl_level <= scl_level_next;
      sda_level <= sda_level_next;
      nack_flag <= nack_flag_next;
      read_reg  <= read_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delay_count    <= delay_count_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      ack_wait_count <= ack_wait_count_next;
      ack_choice     <= ack_choice_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.scl_out   <= scl_level_next;
      res.sda_out   <= sda_level_next;
      res.busy_res  <= (phase_next != i2c_mbe_pkg::PH_IDLE);
      res.done_res  <= done;
      res.read_data <= read_reg_next;
      res.no_ack    <= nack_flag_next;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase register is not one-hot");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res |-> !res.busy_res)
    else $error("done beat reported while still busy");

  a_beat_registered: assert property (@(posedge clk) disable iff (rst)
    cmd.valid && cmd.ready |=> res.valid)
    else $error("accepted beat produced no result");

  a_idle_holds_bus: assert property (@(posedge clk) disable iff (rst)
    accept && phase == i2c_mbe_pkg::PH_IDLE && cmd.operation == i2c_mbe_pkg::OP_TICK
    |=> $stable(scl_level) && $stable(sda_level))
    else $error("tick while idle changed the bus levels");
`endif

endmodule
